// ----- rtl/core/query_command_parser_macros.svh -----
// Assertion macros used by the query command parser RTL
`ifndef QUERY_COMMAND_PARSER_MACROS_SVH
`define QUERY_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define QCP_ASSERT_NOW(label, clk, rst, cond, check) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
      else $error("qcp check failed");

// Next-cycle implication, checked outside reset
`define QCP_ASSERT_NEXT(label, clk, rst, cond, check) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
      else $error("qcp check failed");

`endif

// ----- rtl/core/qcp_pkg.sv -----
// Types, codes and keyword tables for the query command parser
`timescale 1ns / 1ps
`default_nettype none
package qcp_pkg;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_REJECT      = 2'd1;
   localparam logic [1:0] STATUS_REJECT_STOP = 2'd2;

   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_STOP    = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;
   localparam logic [1:0] CMD_PROFILE = 2'd3;

   localparam logic [1:0] KEY_OTHER = 2'd0;
   localparam logic [1:0] KEY_ID    = 2'd1;
   localparam logic [1:0] KEY_ARG   = 2'd2;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam int WORD_COUNT    = 6;
   localparam int WORD_CMD_BASE = 2;
   localparam logic [15:0] ARG_MAX = 16'hFFFF;

   localparam int FIFO_DEPTH = 4;

   // Classified input item as it travels through the queue
   typedef struct packed {
      logic       kind;
      logic [7:0] char_byte;
      logic       is_zero;
      logic       is_amp;
      logic       is_eq;
      logic       is_pct;
      logic       hex_ok;
      logic [3:0] hex_val;
   } qcp_item_type;

   // Length of each keyword: id arg start stop clear profile
   function automatic logic [3:0] word_len(input int k);
      logic [3:0] r;
      begin
         case (k)
            0:       r = 4'd2;
            1:       r = 4'd3;
            2:       r = 4'd5;
            3:       r = 4'd4;
            4:       r = 4'd5;
            5:       r = 4'd7;
            default: r = 4'd0;
         endcase
         return r;
      end
   endfunction

   // Character of a keyword at a position
   function automatic logic [7:0] word_char(input int k, input logic [2:0] pos);
      logic [55:0] w;
      begin
         case (k)
            0:       w = {"id", 40'h0};
            1:       w = {"arg", 32'h0};
            2:       w = {"start", 16'h0};
            3:       w = {"stop", 24'h0};
            4:       w = {"clear", 16'h0};
            5:       w = "profile";
            default: w = '0;
         endcase
         return w[8'(55 - 8 * int'(pos)) -: 8];
      end
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/qcp_front.sv -----
// Input classifier: tags each query byte with its character class and hex value
`timescale 1ns / 1ps
`default_nettype none
module qcp_front import qcp_pkg::*; (
   input  wire logic         req_kind,
   input  wire logic [7:0]   req_char_byte,
   output qcp_item_type      item
);

   logic [7:0] c;

   // Classify the byte
   always_comb begin
      c = req_char_byte;
      item.kind      = req_kind;
      item.char_byte = c;
      item.is_zero   = (c == 8'h00);
      item.is_amp    = (c == "&");
      item.is_eq     = (c == "=");
      item.is_pct    = (c == "%");
      item.hex_ok    = 1'b1;
      item.hex_val   = 4'd0;
      if (c >= "0" && c <= "9") begin
         item.hex_val = 4'(c - "0");
      end else if (c >= "a" && c <= "f") begin
         item.hex_val = 4'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
         item.hex_val = 4'(c - "A" + 8'd10);
      end else begin
         item.hex_ok = 1'b0;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/qcp_fifo.sv -----
// Short queue between the classifier and the parser
`timescale 1ns / 1ps
`default_nettype none
module qcp_fifo import qcp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  qcp_item_type push_item,
   output logic         full,
   input  wire logic    pop,
   output logic         not_empty,
   output qcp_item_type head
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   qcp_item_type             mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]           count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store a transfer
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/qcp_back.sv -----
// Parser: decodes segments, tracks keys and values, and registers the verdict
`timescale 1ns / 1ps
`default_nettype none
`include "query_command_parser_macros.svh"
module qcp_back import qcp_pkg::*; #(
   parameter int TOKEN_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        item_valid,
   input  qcp_item_type     item,
   output logic             item_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [1:0]       rsp_command,
   output logic [15:0]      rsp_argument
);

   localparam int LEN_W = $clog2(TOKEN_BYTES);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(TOKEN_BYTES - 1);

   logic [15:0]       profile_count_ff;
   logic              in_value_ff, in_value_in;
   logic [1:0]        escape_phase_ff, escape_phase_in;
   logic [3:0]        high_nibble_ff, high_nibble_in;
   logic [LEN_W-1:0]  token_length_ff, token_length_in;
   logic              token_error_ff, token_error_in;
   logic [5:0]        word_hits_ff, word_hits_in;
   logic [1:0]        key_kind_ff, key_kind_in;
   logic [15:0]       digit_value_ff, digit_value_in;
   logic              digits_only_ff, digits_only_in;
   logic              segment_started_ff, segment_started_in;
   logic              content_ended_ff, content_ended_in;
   logic              have_command_ff, have_command_in;
   logic              have_argument_ff, have_argument_in;
   logic              ambiguous_ff, ambiguous_in;
   logic              malformed_ff, malformed_in;
   logic              stop_seen_ff, stop_seen_in;
   logic [1:0]        command_code_ff, command_code_in;
   logic [15:0]       argument_value_ff, argument_value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [1:0]        rsp_command_ff, rsp_command_in;
   logic [15:0]       rsp_argument_ff, rsp_argument_in;

   logic              out_free;
   logic              is_end;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign is_end       = (item.kind == KIND_END);
   assign item_pop     = item_valid && (!is_end || out_free);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_command  = rsp_command_ff;
   assign rsp_argument = rsp_argument_ff;

   // Parse one transfer
   always_comb begin
      logic        close_seg, close_key, decode, finish, tok_bad, value_bad, found;
      logic        emit;
      logic [7:0]  d;
      logic [19:0] prod;
      logic        bad;

      in_value_in        = in_value_ff;
      escape_phase_in    = escape_phase_ff;
      high_nibble_in     = high_nibble_ff;
      token_length_in    = token_length_ff;
      token_error_in     = token_error_ff;
      word_hits_in       = word_hits_ff;
      key_kind_in        = key_kind_ff;
      digit_value_in     = digit_value_ff;
      digits_only_in     = digits_only_ff;
      segment_started_in = segment_started_ff;
      content_ended_in   = content_ended_ff;
      have_command_in    = have_command_ff;
      have_argument_in   = have_argument_ff;
      ambiguous_in       = ambiguous_ff;
      malformed_in       = malformed_ff;
      stop_seen_in       = stop_seen_ff;
      command_code_in    = command_code_ff;
      argument_value_in  = argument_value_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_command_in     = rsp_command_ff;
      rsp_argument_in    = rsp_argument_ff;

      close_seg = 1'b0;
      close_key = 1'b0;
      decode    = 1'b0;
      finish    = 1'b0;
      emit      = 1'b0;
      d         = item.char_byte;
      found     = 1'b0;
      value_bad = 1'b0;
      prod      = '0;
      bad       = 1'b0;

      // Sort the transfer into an action
      if (item_pop) begin
         if (is_end) begin
            close_seg = !content_ended_ff && segment_started_ff;
            finish    = 1'b1;
         end else if (!content_ended_ff) begin
            if (item.is_zero) begin
               close_seg        = segment_started_ff;
               content_ended_in = 1'b1;
            end else if (item.is_amp) begin
               close_seg = 1'b1;
            end else begin
               segment_started_in = 1'b1;
               if (item.is_eq && !in_value_ff) begin
                  close_key = 1'b1;
               end else begin
                  decode = 1'b1;
               end
            end
         end
      end

      tok_bad = token_error_ff || (escape_phase_ff != 2'd0);

      // Close the key token
      if (close_key || (close_seg && !in_value_ff)) begin
         key_kind_in = KEY_OTHER;
         if (tok_bad) begin
            malformed_in = 1'b1;
         end else if (word_hits_ff[0] && token_length_ff == LEN_W'(word_len(0))) begin
            key_kind_in = KEY_ID;
         end else if (word_hits_ff[1] && token_length_ff == LEN_W'(word_len(1))) begin
            key_kind_in = KEY_ARG;
         end
         in_value_in = 1'b1;
      end

      // Close the segment
      if (close_seg) begin
         value_bad = !in_value_ff || tok_bad;
         if (value_bad) begin
            malformed_in = 1'b1;
         end
         if (key_kind_in == KEY_ID) begin
            if (have_command_ff) begin
               ambiguous_in = 1'b1;
            end
            have_command_in = 1'b1;
            if (!value_bad) begin
               for (int k = WORD_CMD_BASE; k < WORD_COUNT; k++) begin
                  if (!found && word_hits_ff[k] &&
                      token_length_ff == LEN_W'(word_len(k))) begin
                     found           = 1'b1;
                     command_code_in = 2'(k - WORD_CMD_BASE);
                     if (2'(k - WORD_CMD_BASE) == CMD_STOP) begin
                        stop_seen_in = 1'b1;
                     end
                  end
               end
            end
            if (!found) begin
               malformed_in = 1'b1;
            end
         end else if (key_kind_in == KEY_ARG) begin
            if (have_argument_ff) begin
               ambiguous_in = 1'b1;
            end
            have_argument_in = 1'b1;
            if (value_bad || token_length_ff == '0 || !digits_only_ff) begin
               malformed_in = 1'b1;
            end else begin
               argument_value_in = digit_value_ff;
            end
         end
         in_value_in        = 1'b0;
         key_kind_in        = KEY_OTHER;
         segment_started_in = 1'b0;
      end

      // Percent-decode one byte
      if (decode && !token_error_ff) begin
         case (escape_phase_ff)
            2'd0: begin
               if (item.is_pct) begin
                  escape_phase_in = 2'd1;
               end else begin
                  emit = 1'b1;
               end
            end
            2'd1: begin
               if (!item.hex_ok) begin
                  token_error_in = 1'b1;
               end else begin
                  high_nibble_in  = item.hex_val;
                  escape_phase_in = 2'd2;
               end
            end
            default: begin
               if (!item.hex_ok) begin
                  token_error_in = 1'b1;
               end else begin
                  escape_phase_in = 2'd0;
                  d = {high_nibble_ff, item.hex_val};
                  if (d == 8'h00) begin
                     token_error_in = 1'b1;
                  end else begin
                     emit = 1'b1;
                  end
               end
            end
         endcase
      end

      // Append a decoded byte to the token
      if (emit) begin
         if (token_length_ff >= LEN_LIMIT) begin
            token_error_in = 1'b1;
         end else begin
            for (int k = 0; k < WORD_COUNT; k++) begin
               if (token_length_ff >= LEN_W'(word_len(k)) ||
                   word_char(k, token_length_ff[2:0]) != d) begin
                  word_hits_in[k] = 1'b0;
               end
            end
            token_length_in = token_length_ff + 1'b1;
            if (digits_only_ff) begin
               if (d >= "0" && d <= "9") begin
                  prod = 20'(digit_value_ff) * 20'd10 + 20'(d - "0");
                  digit_value_in = prod[15:0];
                  if (prod > 20'(ARG_MAX)) begin
                     digits_only_in = 1'b0;
                  end
               end else begin
                  digits_only_in = 1'b0;
               end
            end
         end
      end

      // Restart the token after any close
      if (close_seg || close_key || finish) begin
         escape_phase_in = 2'd0;
         high_nibble_in  = 4'd0;
         token_length_in = '0;
         token_error_in  = 1'b0;
         word_hits_in    = '1;
         digit_value_in  = '0;
         digits_only_in  = 1'b1;
      end

      // Form the verdict and clear the query
      if (finish) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = STATUS_REJECT;
         rsp_command_in  = CMD_START;
         rsp_argument_in = '0;
         if (have_command_in) begin
            bad = ambiguous_in || malformed_in ||
                  (command_code_in == CMD_PROFILE &&
                   (!have_argument_in || argument_value_in >= profile_count_ff));
            if (bad) begin
               if (stop_seen_in) begin
                  rsp_status_in  = STATUS_REJECT_STOP;
                  rsp_command_in = CMD_STOP;
               end
            end else begin
               rsp_status_in  = STATUS_OK;
               rsp_command_in = command_code_in;
               if (command_code_in == CMD_PROFILE) begin
                  rsp_argument_in = argument_value_in;
               end
            end
         end
         in_value_in        = 1'b0;
         key_kind_in        = KEY_OTHER;
         segment_started_in = 1'b0;
         content_ended_in   = 1'b0;
         have_command_in    = 1'b0;
         have_argument_in   = 1'b0;
         ambiguous_in       = 1'b0;
         malformed_in       = 1'b0;
         stop_seen_in       = 1'b0;
         command_code_in    = CMD_START;
         argument_value_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         profile_count_ff   <= '0;
         in_value_ff        <= 1'b0;
         escape_phase_ff    <= 2'd0;
         high_nibble_ff     <= 4'd0;
         token_length_ff    <= '0;
         token_error_ff     <= 1'b0;
         word_hits_ff       <= '1;
         key_kind_ff        <= KEY_OTHER;
         digit_value_ff     <= '0;
         digits_only_ff     <= 1'b1;
         segment_started_ff <= 1'b0;
         content_ended_ff   <= 1'b0;
         have_command_ff    <= 1'b0;
         have_argument_ff   <= 1'b0;
         ambiguous_ff       <= 1'b0;
         malformed_ff       <= 1'b0;
         stop_seen_ff       <= 1'b0;
         command_code_ff    <= CMD_START;
         argument_value_ff  <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            profile_count_ff <= csr_write_data;
         end
         in_value_ff        <= in_value_in;
         escape_phase_ff    <= escape_phase_in;
         high_nibble_ff     <= high_nibble_in;
         token_length_ff    <= token_length_in;
         token_error_ff     <= token_error_in;
         word_hits_ff       <= word_hits_in;
         key_kind_ff        <= key_kind_in;
         digit_value_ff     <= digit_value_in;
         digits_only_ff     <= digits_only_in;
         segment_started_ff <= segment_started_in;
         content_ended_ff   <= content_ended_in;
         have_command_ff    <= have_command_in;
         have_argument_ff   <= have_argument_in;
         ambiguous_ff       <= ambiguous_in;
         malformed_ff       <= malformed_in;
         stop_seen_ff       <= stop_seen_in;
         command_code_ff    <= command_code_in;
         argument_value_ff  <= argument_value_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Result payload holds while a transfer waits
   always_ff @(posedge clock) begin
      if (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_command_ff  <= rsp_command_in;
         rsp_argument_ff <= rsp_argument_in;
      end
   end

   `QCP_ASSERT_NOW(a_stop_reject_cmd, clock, reset, rsp_valid_ff && rsp_status_ff == STATUS_REJECT_STOP, rsp_command_ff == CMD_STOP)
   `QCP_ASSERT_NOW(a_arg_only_profile, clock, reset, rsp_valid_ff && rsp_command_ff != CMD_PROFILE, rsp_argument_ff == '0)
   `QCP_ASSERT_NOW(a_no_end_when_blocked, clock, reset, item_pop && is_end, out_free)
   `QCP_ASSERT_NOW(a_ended_no_segment, clock, reset, content_ended_ff, !segment_started_ff)
   `QCP_ASSERT_NEXT(a_end_gives_result, clock, reset, item_pop && is_end, rsp_valid_ff)

endmodule
`default_nettype wire

// ----- rtl/core/query_command_parser.sv -----
// Top level of the query command parser: classifier, queue and parser
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid req_stall req_kind req_char_byte  | in
//  rsp     | rsp_valid rsp_stall rsp_status rsp_command rsp_argument | out
//  csr     | csr_write_enable csr_write_data         | in
//
// One item per cycle while the queue holds one; an end item waits while a verdict is stalled.
// A verdict appears in the cycle after its end item leaves the queue.
// The four-entry queue lets bytes keep flowing while a verdict waits to be taken.
// Synchronous reset clears all parse state and sets profile_count to 0.
`timescale 1ns / 1ps
`default_nettype none
module query_command_parser import qcp_pkg::*; #(
   parameter int TOKEN_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_char_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [1:0]       rsp_command,
   output logic [15:0]      rsp_argument,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   qcp_item_type in_item, head_item;
   logic         full, not_empty, pop;

   assign req_stall = full;

   qcp_front u_front (
      .req_kind      (req_kind),
      .req_char_byte (req_char_byte),
      .item          (in_item)
   );

   qcp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !full),
      .push_item (in_item),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head_item)
   );

   qcp_back #(.TOKEN_BYTES(TOKEN_BYTES)) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (not_empty),
      .item             (head_item),
      .item_pop         (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_command      (rsp_command),
      .rsp_argument     (rsp_argument)
   );

endmodule
`default_nettype wire

// ----- dv/query_command_checker.sv -----
// Checker for the query command parser: predicts verdicts and compares them
`timescale 1ns / 1ps
`default_nettype none
module query_command_checker import qcp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [1:0]  rsp_command,
   input  wire logic [15:0] rsp_argument,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   output int               error_count,
   output int               pending_count
);
   localparam int TOKEN_LIMIT = 15;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  command;
      logic [15:0] argument;
   } verdict_type;

   verdict_type verdict_queue[$];

   // Parser shadow state
   logic [15:0] profile_limit;
   bit          in_value, token_error, digits_only, segment_started, content_ended;
   bit          have_command, have_argument, ambiguous, malformed, stop_seen;
   int unsigned escape_phase, high_nibble, token_length, word_hits, key_kind;
   int unsigned digit_value, command_code, argument_value;
   string       keywords[6] = '{"id", "arg", "start", "stop", "clear", "profile"};

   assign pending_count = verdict_queue.size();

   function automatic int hex_nibble(input int unsigned c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic void open_token();
      escape_phase = 0;
      high_nibble = 0;
      token_length = 0;
      token_error = 0;
      word_hits = 6'h3F;
      digit_value = 0;
      digits_only = 1;
   endfunction

   function automatic void clear_query();
      in_value = 0;
      key_kind = KEY_OTHER;
      segment_started = 0;
      content_ended = 0;
      have_command = 0;
      have_argument = 0;
      ambiguous = 0;
      malformed = 0;
      stop_seen = 0;
      command_code = 0;
      argument_value = 0;
      open_token();
   endfunction

   // Add one decoded byte to the current token
   function automatic void take_decoded(input int unsigned d);
      if (token_length >= TOKEN_LIMIT) begin
         token_error = 1;
         return;
      end
      for (int k = 0; k < WORD_COUNT; k++) begin
         if (word_hits[k] && (token_length >= keywords[k].len() ||
                              keywords[k][token_length] != d))
            word_hits[k] = 0;
      end
      token_length++;
      if (digits_only) begin
         if (d >= "0" && d <= "9") begin
            digit_value = digit_value * 10 + (d - "0");
            if (digit_value > ARG_MAX) digits_only = 0;
         end else begin
            digits_only = 0;
         end
      end
   endfunction

   function automatic void decode_char(input int unsigned c);
      int h;
      if (token_error) return;
      if (escape_phase == 0) begin
         if (c == "%") escape_phase = 1;
         else take_decoded(c);
      end else begin
         h = hex_nibble(c);
         if (h < 0) begin
            token_error = 1;
            return;
         end
         if (escape_phase == 1) begin
            high_nibble = h;
            escape_phase = 2;
         end else begin
            escape_phase = 0;
            if (high_nibble * 16 + h == 0) token_error = 1;
            else take_decoded(high_nibble * 16 + h);
         end
      end
   endfunction

   function automatic bit token_bad();
      return token_error || escape_phase != 0;
   endfunction

   function automatic void close_key();
      key_kind = KEY_OTHER;
      if (token_bad()) malformed = 1;
      else if (word_hits[0] && token_length == 2) key_kind = KEY_ID;
      else if (word_hits[1] && token_length == 3) key_kind = KEY_ARG;
      in_value = 1;
      open_token();
   endfunction

   function automatic void close_segment();
      bit value_bad, found;
      found = 0;
      if (!in_value) begin
         close_key();
         value_bad = 1;
      end else begin
         value_bad = token_bad();
      end
      if (value_bad) malformed = 1;
      if (key_kind == KEY_ID) begin
         if (have_command) ambiguous = 1;
         have_command = 1;
         if (!value_bad) begin
            for (int k = WORD_CMD_BASE; k < WORD_COUNT && !found; k++) begin
               if (word_hits[k] && token_length == keywords[k].len()) begin
                  command_code = k - WORD_CMD_BASE;
                  if (command_code == CMD_STOP) stop_seen = 1;
                  found = 1;
               end
            end
         end
         if (!found) malformed = 1;
      end else if (key_kind == KEY_ARG) begin
         if (have_argument) ambiguous = 1;
         have_argument = 1;
         if (value_bad || token_length == 0 || !digits_only) malformed = 1;
         else argument_value = digit_value;
      end
      in_value = 0;
      key_kind = KEY_OTHER;
      segment_started = 0;
      open_token();
   endfunction

   // Advance the shadow parser by one transfer; end items queue a verdict
   function automatic void parse_transfer(input logic kind, input logic [7:0] c);
      verdict_type v;
      if (kind == KIND_BYTE) begin
         if (content_ended) return;
         if (c == 8'h00) begin
            if (segment_started) close_segment();
            content_ended = 1;
         end else if (c == "&") begin
            close_segment();
         end else begin
            segment_started = 1;
            if (c == "=" && !in_value) close_key();
            else decode_char(c);
         end
         return;
      end
      if (!content_ended && segment_started) close_segment();
      v = '{STATUS_REJECT, CMD_START, 16'd0};
      if (have_command) begin
         if (ambiguous || malformed || (command_code == CMD_PROFILE &&
               (!have_argument || argument_value >= profile_limit))) begin
            if (stop_seen) v = '{STATUS_REJECT_STOP, CMD_STOP, 16'd0};
         end else begin
            v.status = STATUS_OK;
            v.command = command_code[1:0];
            v.argument = (command_code == CMD_PROFILE) ? argument_value[15:0] : 16'd0;
         end
      end
      verdict_queue.push_back(v);
      clear_query();
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         profile_limit <= 16'd0;
         clear_query();
         verdict_queue.delete();
         error_count <= 0;
      end else begin
         if (csr_write_enable) profile_limit <= csr_write_data;
         if (req_valid && !req_stall) parse_transfer(req_kind, req_char_byte);
         // Compare each accepted verdict with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: unexpected verdict status=%0d command=%0d argument=%0d",
                        $time, rsp_status, rsp_command, rsp_argument);
               error_count <= error_count + 1;
            end else begin
               want = verdict_queue.pop_front();
               if (want.status !== rsp_status || want.command !== rsp_command ||
                   want.argument !== rsp_argument) begin
                  $display("%0t: verdict mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d",
                           $time, want.status, want.command, want.argument,
                           rsp_status, rsp_command, rsp_argument);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench top for the query command parser: stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import qcp_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_kind = 0;
   logic [7:0]  req_char_byte = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_command;
   logic [15:0] rsp_argument;
   logic        csr_write_enable = 0;
   logic [15:0] csr_write_data = 0;
   int          error_count;
   int          pending_count;
   int          idle_percent = 38;
   int          sent_items = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   query_command_parser DUT (.*);
   query_command_checker checker_inst (.*);

   // Receiver stall, random except in the quiet stretch
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < idle_percent);

   // Present one item and hold it until the transfer; valid stays high until an idle gap or the next item
   task automatic send_item(input logic kind, input logic [7:0] c);
      while ($urandom_range(99) < idle_percent) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_char_byte <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_query(input string q);
      for (int i = 0; i < q.len(); i++) send_item(KIND_BYTE, q[i]);
      send_item(KIND_END, 8'h00);
   endtask

   // Wait for all verdicts, then let the pipeline drain before a write
   task automatic drain_and_write(input logic [15:0] value);
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic string random_token(input bit numeric);
      string words[10] = '{"start", "stop", "clear", "profile", "st%61rt", "%73top",
                           "bogus", "%zz", "%4", "%00"};
      string s;
      int n;
      s = "";
      if (numeric) begin
         case ($urandom_range(4))
            0: s = "0";
            1: s = "65535";
            2: s = "65536";
            default: s.itoa($urandom_range(20));
         endcase
         return s;
      end
      if ($urandom_range(9) < 7) return words[$urandom_range(9)];
      n = $urandom_range(17);
      for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(33, 126)))};
      return s;
   endfunction

   function automatic string random_query();
      string q, key;
      int segs;
      q = "";
      segs = $urandom_range(3);
      for (int i = 0; i < segs; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: q = {q, "id=", random_token(0)};
            4, 5, 6:    q = {q, "arg=", random_token(1)};
            7:          q = {q, "%69d=", random_token(0)};
            8:          q = {q, random_token(0)};
            default: begin
               key = random_token(0);
               q = {q, key, "=", random_token(1'($urandom_range(1)))};
            end
         endcase
         if (i + 1 < segs || $urandom_range(9) == 0) q = {q, "&"};
      end
      return q;
   endfunction

   initial begin
      string directed[] = '{"", "id=start", "id=stop", "id=clear", "id=profile&arg=3",
         "id=profile&arg=9", "id=profile", "&id=start", "id=start&", "id",
         "id=start&id=stop", "id=stop&arg=x", "%ZZ=1&id=clear", "id=st%4",
         "id=%00", "arg=65535&id=profile", "arg=65536&id=profile",
         "id=clearaaaaaaaaaaaaaaa", "x=1&id=st%61rt", "id=cl%", "i%64=stop&arg=1"};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      drain_and_write(16'd5);
      foreach (directed[i]) send_query(directed[i]);
      // Zero byte ends content; later bytes are ignored
      send_item(KIND_BYTE, "i");
      send_item(KIND_BYTE, "d");
      send_item(KIND_BYTE, "=");
      send_item(KIND_BYTE, "s");
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_BYTE, 8'hFF);
      send_item(KIND_END, 8'h00);
      drain_and_write(16'hFFFF);
      send_query("id=profile&arg=65534");
      send_query("id=profile&arg=65535");
      drain_and_write(16'd0);
      send_query("id=profile&arg=0");
      // Random queries through several profile limits
      for (int phase = 0; phase < 4; phase++) begin
         drain_and_write(phase == 3 ? 16'hFFFF : 16'($urandom_range(20)));
         idle_percent = (phase == 2) ? 0 : 38;
         while (sent_items < 100 * (phase + 1) + 60) begin
            if ($urandom_range(19) == 0) begin
               send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end else begin
               send_query(random_query());
            end
         end
      end
      req_valid <= 0;
      idle_percent = 38;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/qcp_pkg.sv
rtl/core/qcp_front.sv
rtl/core/qcp_fifo.sv
rtl/core/qcp_back.sv
rtl/core/query_command_parser.sv
dv/query_command_checker.sv
dv/tb.sv
